// File: hw/rtl/byte_ring_fifo_peek_advance_assert.svh
// Assertion macros used by the FIFO datapath.
`ifndef BYTE_RING_FIFO_PEEK_ADVANCE_ASSERT_SVH
`define BYTE_RING_FIFO_PEEK_ADVANCE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BRFPA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BRFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/brfpa_pkg.sv
`default_nettype none
package brfpa_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int PTR_W  = 8;
	localparam int SIZE_W = 9;
	localparam int OP_W   = 3;
	localparam int OFS_W  = 9;
	localparam int ST_W   = 2;
	localparam int BYTE_W = 8;

	localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_W-1:0] OP_POP     = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
	localparam logic [OP_W-1:0] OP_ADVANCE = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [ST_W-1:0] ST_PARAM = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
	} brfpa_cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/brfpa_ram.sv
`default_nettype none
module brfpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/brfpa_ctrl.sv
`default_nettype none
module brfpa_ctrl
	import brfpa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output brfpa_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RESP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   accept;

	assign accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE, S_RESP: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_EXEC: begin
					state_q <= S_RESP;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy        = busy_q;
	assign done        = done_q;
	assign cmd.capture = accept;
	assign cmd.exec    = (state_q == S_EXEC);

endmodule
`default_nettype wire

// File: hw/rtl/brfpa_datapath.sv
`default_nettype none
`include "byte_ring_fifo_peek_advance_assert.svh"
module brfpa_datapath
	import brfpa_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire brfpa_cmd_t        cmd,
	input  wire logic [OP_W-1:0]   opcode,
	input  wire logic [BYTE_W-1:0] write_byte,
	input  wire logic [OFS_W-1:0]  offset,
	input  wire logic              ring_size_we,
	input  wire logic [SIZE_W-1:0] ring_size,
	output logic      [ST_W-1:0]   status,
	output logic      [BYTE_W-1:0] read_byte,
	output logic      [PTR_W-1:0]  fill_level
);

	localparam int CAP    = (STORE_DEPTH < 256) ? STORE_DEPTH : 256;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(CAP);
	localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);

	logic [OP_W-1:0]   opcode_q;
	logic [BYTE_W-1:0] wbyte_q;
	logic [OFS_W-1:0]  offset_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [SIZE_W-1:0] size_q;
	logic [ST_W-1:0]   status_q;
	logic [PTR_W-1:0]  fill_q;
	logic              rd_sel_q;

	logic [SIZE_W-1:0] fill_w;
	logic [PTR_W-1:0]  fill;
	logic [SIZE_W:0]   ofs_sum;
	logic [PTR_W-1:0]  ofs_ptr;
	logic [SIZE_W-1:0] wr_inc;
	logic [PTR_W-1:0]  wr_next;
	logic [SIZE_W-1:0] rd_inc;
	logic [PTR_W-1:0]  rd_next;
	logic              is_full;
	logic              is_empty;

	logic [ST_W-1:0]   st_d;
	logic [PTR_W-1:0]  wr_d;
	logic [PTR_W-1:0]  rd_d;
	logic [PTR_W-1:0]  fill_d;
	logic              rd_sel_d;
	logic              ram_we;
	logic [PTR_W-1:0]  ram_rptr;
	logic [BYTE_W-1:0] ram_rdata;
	logic [ADDR_W+PTR_W-1:0] waddr_ext;
	logic [ADDR_W+PTR_W-1:0] raddr_ext;

	// Pointers always stay below the ring size, so no reduction is needed here.
	always_comb begin
		if (wr_ptr_q >= rd_ptr_q) begin
			fill_w = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
		end else begin
			fill_w = {1'b0, wr_ptr_q} + size_q - {1'b0, rd_ptr_q};
		end
		fill     = fill_w[PTR_W-1:0];
		is_full  = ({1'b0, fill} >= (size_q - SIZE_W'(1)));
		is_empty = (fill == '0);

		// The offset is checked against the fill level, so one wrap is enough.
		ofs_sum = {2'b00, rd_ptr_q} + {1'b0, offset_q};
		if (ofs_sum >= {1'b0, size_q}) begin
			ofs_sum = ofs_sum - {1'b0, size_q};
		end
		ofs_ptr = ofs_sum[PTR_W-1:0];

		wr_inc  = {1'b0, wr_ptr_q} + SIZE_W'(1);
		wr_next = (wr_inc == size_q) ? '0 : wr_inc[PTR_W-1:0];
		rd_inc  = {1'b0, rd_ptr_q} + SIZE_W'(1);
		rd_next = (rd_inc == size_q) ? '0 : rd_inc[PTR_W-1:0];
	end

	always_comb begin
		st_d     = ST_OK;
		wr_d     = wr_ptr_q;
		rd_d     = rd_ptr_q;
		fill_d   = fill;
		rd_sel_d = 1'b0;
		ram_we   = 1'b0;
		ram_rptr = rd_ptr_q;
		case (opcode_q)
			OP_PUSH: begin
				if (is_full) begin
					st_d = ST_FULL;
				end else begin
					ram_we = cmd.exec;
					wr_d   = wr_next;
					fill_d = fill + PTR_W'(1);
				end
			end
			OP_POP: begin
				if (is_empty) begin
					st_d = ST_EMPTY;
				end else begin
					rd_sel_d = 1'b1;
					rd_d     = rd_next;
					fill_d   = fill - PTR_W'(1);
				end
			end
			OP_PEEK: begin
				ram_rptr = ofs_ptr;
				if (is_empty) begin
					st_d = ST_EMPTY;
				end else if (offset_q >= {1'b0, fill}) begin
					st_d = ST_PARAM;
				end else begin
					rd_sel_d = 1'b1;
				end
			end
			OP_ADVANCE: begin
				if (offset_q > {1'b0, fill}) begin
					st_d = ST_PARAM;
				end else begin
					rd_d   = ofs_ptr;
					fill_d = fill - offset_q[PTR_W-1:0];
				end
			end
			OP_CLEAR: begin
				wr_d   = '0;
				rd_d   = '0;
				fill_d = '0;
			end
			default: begin
				st_d = ST_PARAM;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			opcode_q <= opcode;
			wbyte_q  <= write_byte;
			offset_q <= offset;
		end
		if (cmd.exec) begin
			status_q <= st_d;
			fill_q   <= fill_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			size_q   <= SIZE_MAX;
			rd_sel_q <= 1'b0;
		end else if (ring_size_we) begin
			// A new ring size empties the FIFO.
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			if (ring_size < SIZE_MIN) begin
				size_q <= SIZE_MIN;
			end else if (ring_size > SIZE_MAX) begin
				size_q <= SIZE_MAX;
			end else begin
				size_q <= ring_size;
			end
		end else if (cmd.exec) begin
			wr_ptr_q <= wr_d;
			rd_ptr_q <= rd_d;
			rd_sel_q <= rd_sel_d;
		end
	end

	assign waddr_ext = {{ADDR_W{1'b0}}, wr_ptr_q};
	assign raddr_ext = {{ADDR_W{1'b0}}, ram_rptr};

	brfpa_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(waddr_ext[ADDR_W-1:0]),
		.wdata(wbyte_q),
		.re   (cmd.exec),
		.raddr(raddr_ext[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	assign status     = status_q;
	assign read_byte  = rd_sel_q ? ram_rdata : '0;
	assign fill_level = fill_q;

	`BRFPA_ASSERT_IMPL(a_wr_ptr_in_ring, clk, arst_n, 1'b1, {1'b0, wr_ptr_q} < size_q, "write pointer beyond ring size")
	`BRFPA_ASSERT_IMPL(a_rd_ptr_in_ring, clk, arst_n, 1'b1, {1'b0, rd_ptr_q} < size_q, "read pointer beyond ring size")
	`BRFPA_ASSERT_NEXT(a_fill_matches, clk, arst_n, cmd.exec && !ring_size_we, fill_q == fill, "reported fill level disagrees with pointers")
	`BRFPA_ASSERT_IMPL(a_write_when_room, clk, arst_n, ram_we, !is_full && cmd.exec, "store written while full")

endmodule
`default_nettype wire

// File: hw/rtl/byte_ring_fifo_peek_advance.sv
// Byte FIFO over a circular store. Each operation (push, pop, peek, advance,
// clear) is taken when start is high and busy is low; busy then stays high for
// the one cycle in which the pointers are updated and the store is accessed,
// and in the cycle after it done is high for exactly one cycle with status,
// read_byte and fill_level. The receiver cannot stall, so the result must be
// taken in that cycle. The read port of the store is registered; a new
// operation may be started in the result cycle. Writing ring_size clears both
// pointers and must only be done while no operation is outstanding.
`default_nettype none
module byte_ring_fifo_peek_advance
	import brfpa_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [OP_W-1:0]   opcode,
	input  wire logic [BYTE_W-1:0] write_byte,
	input  wire logic [OFS_W-1:0]  offset,
	output logic                   done,
	output logic      [ST_W-1:0]   status,
	output logic      [BYTE_W-1:0] read_byte,
	output logic      [PTR_W-1:0]  fill_level,
	input  wire logic              ring_size_we,
	input  wire logic [SIZE_W-1:0] ring_size
);

	brfpa_cmd_t cmd;

	brfpa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	brfpa_datapath #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.opcode      (opcode),
		.write_byte  (write_byte),
		.offset      (offset),
		.ring_size_we(ring_size_we),
		.ring_size   (ring_size),
		.status      (status),
		.read_byte   (read_byte),
		.fill_level  (fill_level)
	);

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none
module tb_top;
	import brfpa_pkg::*;

	localparam logic [OP_W-1:0] OP_TOP = '1;
	localparam int RING_CAP = (STORE_DEPTH_DEF < 256) ? STORE_DEPTH_DEF : 256;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] data;
		logic [OFS_W-1:0]  ofs;
	} fifo_cmd_t;

	typedef struct packed {
		logic [ST_W-1:0]   st;
		logic [BYTE_W-1:0] rbyte;
		logic [PTR_W-1:0]  level;
	} fifo_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [OP_W-1:0] opcode = OP_PUSH;
	logic [BYTE_W-1:0] write_byte = '0;
	logic [OFS_W-1:0] offset = '0;
	logic ring_size_we = 1'b0;
	logic [SIZE_W-1:0] ring_size = '0;
	logic busy;
	logic done;
	logic [ST_W-1:0] status;
	logic [BYTE_W-1:0] read_byte;
	logic [PTR_W-1:0] fill_level;

	fifo_cmd_t cmd_queue[$];
	fifo_result_t result_queue[$];
	int fail_count = 0;
	int gap_left = 0;
	bit no_gaps = 1'b0;

	// Shadow state of the FIFO.
	logic [BYTE_W-1:0] shadow_mem [0:255];
	int wr_ptr = 0;
	int rd_ptr = 0;
	logic [SIZE_W-1:0] size_reg = 9'd256;

	byte_ring_fifo_peek_advance dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.write_byte(write_byte),
		.offset(offset),
		.done(done),
		.status(status),
		.read_byte(read_byte),
		.fill_level(fill_level),
		.ring_size_we(ring_size_we),
		.ring_size(ring_size)
	);

	always #1 clk = ~clk;

	function automatic int ring_eff();
		int s;
		s = int'(size_reg);
		if (s < 2) s = 2;
		if (s > RING_CAP) s = RING_CAP;
		return s;
	endfunction

	function automatic int occupancy(input int sz);
		return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + sz - rd_ptr;
	endfunction

	function automatic fifo_result_t fifo_apply(input logic [OP_W-1:0] op,
			input logic [BYTE_W-1:0] data, input logic [OFS_W-1:0] ofs);
		fifo_result_t r;
		int sz;
		int lvl;
		sz = ring_eff();
		r = '0;
		r.st = ST_OK;
		wr_ptr = wr_ptr % sz;
		rd_ptr = rd_ptr % sz;
		lvl = occupancy(sz);
		case (op)
			OP_PUSH: begin
				if (lvl >= sz - 1) begin
					r.st = ST_FULL;
				end else begin
					shadow_mem[wr_ptr] = data;
					wr_ptr = (wr_ptr + 1) % sz;
				end
			end
			OP_POP: begin
				if (lvl == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.rbyte = shadow_mem[rd_ptr];
					rd_ptr = (rd_ptr + 1) % sz;
				end
			end
			OP_PEEK: begin
				if (lvl == 0) r.st = ST_EMPTY;
				else if (int'(ofs) >= lvl) r.st = ST_PARAM;
				else r.rbyte = shadow_mem[(rd_ptr + int'(ofs)) % sz];
			end
			OP_ADVANCE: begin
				if (int'(ofs) > lvl) r.st = ST_PARAM;
				else rd_ptr = (rd_ptr + int'(ofs)) % sz;
			end
			OP_CLEAR: begin
				wr_ptr = 0;
				rd_ptr = 0;
			end
			default: begin
				r.st = ST_PARAM;
			end
		endcase
		r.level = PTR_W'(occupancy(sz));
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report(input string what);
		fail_count++;
		if (fail_count <= 50) $display("ERROR at %0t: %s", $time, what);
	endtask

	task automatic add_cmd(input logic [OP_W-1:0] op, input int data, input int ofs);
		fifo_cmd_t c;
		c.op = op;
		c.data = BYTE_W'(data);
		c.ofs = OFS_W'(ofs);
		cmd_queue.push_back(c);
	endtask

	function automatic int rand_ofs(input int eff);
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return $urandom_range(0, 3);
		if (r < 80) return $urandom_range(0, eff);
		if (r < 95) return $urandom_range(0, 256);
		return 256;
	endfunction

	function automatic logic [OP_W-1:0] rand_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return OP_PUSH;
		if (r < 50) return OP_POP;
		if (r < 75) return OP_PEEK;
		if (r < 90) return OP_ADVANCE;
		if (r < 94) return OP_CLEAR;
		return OP_W'($urandom_range(int'(OP_CLEAR) + 1, int'(OP_TOP)));
	endfunction

	// Runs of pushes and pops let the FIFO reach full and empty at the smaller
	// sizes and run deep at the larger ones; mixed runs exercise peeks and
	// advances against a partly filled ring. Each phase sends exactly its budget.
	task automatic random_phase(input int budget);
		int n;
		int eff;
		int kind;
		int len;
		eff = ring_eff();
		n = 0;
		while (n < budget) begin
			kind = $urandom_range(0, 9);
			if (kind < 5) len = $urandom_range(1, eff);
			else len = $urandom_range(4, 16);
			if (len > budget - n) len = budget - n;
			repeat (len) begin
				if (kind < 3)
					add_cmd(OP_PUSH, $urandom_range(0, 255), rand_ofs(eff));
				else if (kind < 5)
					add_cmd(OP_POP, $urandom_range(0, 255), rand_ofs(eff));
				else
					add_cmd(rand_op(), $urandom_range(0, 255), rand_ofs(eff));
			end
			n += len;
		end
	endtask

	// Checked on the falling edge, once the driver and monitor have settled.
	task automatic wait_drained();
		while (cmd_queue.size() != 0 || result_queue.size() != 0 || start)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic set_ring_size(input int value);
		@(posedge clk);
		ring_size_we <= 1'b1;
		ring_size <= SIZE_W'(value);
		@(posedge clk);
		ring_size_we <= 1'b0;
		ring_size <= SIZE_W'($urandom_range(0, 511));
		size_reg = SIZE_W'(value);
		wr_ptr = 0;
		rd_ptr = 0;
	endtask

	// Driver: a transaction is taken at an edge where start is high and busy low.
	always @(posedge clk) begin
		fifo_cmd_t c;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) result_queue.push_back(fifo_apply(opcode, write_byte, offset));
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (cmd_queue.size() != 0) begin
					c = cmd_queue.pop_front();
					opcode <= c.op;
					write_byte <= c.data;
					offset <= c.ofs;
					start <= 1'b1;
					gap_left = pick_gap();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: results cannot be held off, so each strobe is checked as it comes.
	always @(posedge clk) begin
		fifo_result_t want;
		if (arst_n && done) begin
			if (result_queue.size() == 0) begin
				report("result strobe with no transaction outstanding");
			end else begin
				want = result_queue.pop_front();
				if (status !== want.st)
					report($sformatf("status %0d, expected %0d", status, want.st));
				if (read_byte !== want.rbyte)
					report($sformatf("read_byte %0h, expected %0h", read_byte, want.rbyte));
				if (fill_level !== want.level)
					report($sformatf("fill_level %0d, expected %0d", fill_level, want.level));
			end
		end
	end

	initial begin
		int sizes[14];
		sizes = '{2, 3, 0, 1, 5, 17, 64, 255, 511, 256, 300, 7, 0, 0};
		sizes[12] = $urandom_range(2, 256);
		sizes[13] = $urandom_range(257, 511);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Empty ring at the reset size, then a few bytes at the extremes.
		add_cmd(OP_PEEK, 0, 0);
		add_cmd(OP_POP, 0, 0);
		add_cmd(OP_ADVANCE, 0, 0);
		add_cmd(OP_ADVANCE, 0, 1);
		add_cmd(OP_PUSH, 8'h00, 0);
		add_cmd(OP_PUSH, 8'hff, 256);
		add_cmd(OP_PUSH, 8'ha5, 0);
		add_cmd(OP_PEEK, 0, 0);
		add_cmd(OP_PEEK, 0, 2);
		add_cmd(OP_PEEK, 0, 3);
		add_cmd(OP_PEEK, 0, 256);
		add_cmd(OP_ADVANCE, 0, 4);
		add_cmd(OP_ADVANCE, 0, 1);
		add_cmd(OP_POP, 0, 0);
		add_cmd(OP_W'(int'(OP_CLEAR) + 1), 0, 0);
		add_cmd(OP_TOP, 8'h55, 1);
		add_cmd(OP_CLEAR, 0, 0);
		add_cmd(OP_POP, 0, 0);
		wait_drained();

		// Smallest ring: a single byte makes it full.
		set_ring_size(2);
		add_cmd(OP_PUSH, 8'h5a, 0);
		add_cmd(OP_PUSH, 8'h11, 0);
		add_cmd(OP_PEEK, 0, 0);
		add_cmd(OP_PEEK, 0, 1);
		add_cmd(OP_POP, 0, 0);
		add_cmd(OP_POP, 0, 0);
		add_cmd(OP_PUSH, 8'h81, 0);
		add_cmd(OP_ADVANCE, 0, 1);
		wait_drained();

		foreach (sizes[i]) begin
			set_ring_size(sizes[i]);
			no_gaps = ($urandom_range(0, 3) == 0);
			random_phase(85);
			wait_drained();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0 && result_queue.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/brfpa_pkg.sv
hw/rtl/brfpa_ram.sv
hw/rtl/brfpa_ctrl.sv
hw/rtl/brfpa_datapath.sv
hw/rtl/byte_ring_fifo_peek_advance.sv
tb/sv/tb_top.sv
